// ----- rtl/core/tfn_pkg.sv -----
// Package for the triangle face normal block.
// Holds the widths, the port payload types and the types passed between pipeline sections.
// No dependencies.
package tfn_pkg;

	localparam int NAXES = 3;

	// input coordinates, Q15.8
	localparam int COORD_W = 24;
	localparam int EDGE_W = COORD_W + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = CROSS_W - 1;

	// normalized magnitudes have their leading one at bit NORM_W-1
	localparam int NORM_W = 31;

	// leading-zero search in byte groups
	localparam int LZ_GRP = 8;
	localparam int LZ_NGRP = (MAG_W + LZ_GRP - 1) / LZ_GRP;
	localparam int LZ_PAD = LZ_NGRP * LZ_GRP;
	localparam int LZ_FILL = LZ_PAD - MAG_W;
	localparam int LZ_W = $clog2(LZ_PAD);
	localparam int GRP_LZ_W = $clog2(LZ_GRP);

	// sum of squares and its integer square root
	localparam int SQ_W = 2 * NORM_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int SQ_REM_W = ROOT_W + 2;

	// output, Q1.14
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_W = 16;
	localparam int QUOT_W = NORMAL_FRAC_BITS + 1;
	localparam int DIVD_W = NORM_W + NORMAL_FRAC_BITS + 1;
	localparam int DIV_REM_W = ROOT_W + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] first_z;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] second_z;
		logic signed [COORD_W-1:0] third_x;
		logic signed [COORD_W-1:0] third_y;
		logic signed [COORD_W-1:0] third_z;
	} triangle_t;

	typedef struct packed {
		logic signed [NORMAL_W-1:0] normal_x;
		logic signed [NORMAL_W-1:0] normal_y;
		logic signed [NORMAL_W-1:0] normal_z;
		logic                       degenerate;
	} normal_t;

	typedef struct packed {
		logic signed [CROSS_W-1:0] x;
		logic signed [CROSS_W-1:0] y;
		logic signed [CROSS_W-1:0] z;
	} cross_t;

	typedef struct packed {
		logic [NAXES-1:0][NORM_W-1:0] mag;
		logic [NAXES-1:0]             neg;
		logic                         degen;
	} scaled_t;

	typedef struct packed {
		logic [NAXES-1:0][NORM_W-1:0] mag;
		logic [NAXES-1:0]             neg;
		logic                         degen;
		logic [ROOT_W-1:0]            root;
	} rooted_t;

	typedef struct packed {
		logic [NAXES-1:0][QUOT_W-1:0] quo;
		logic [NAXES-1:0]             neg;
		logic                         degen;
	} quot_t;

endpackage

// ----- rtl/core/triangle_face_normal.sv -----
// Unit face normal of a triangle: N = (p2 - p1) x (p3 - p1) scaled to length one, Q1.14 out.
// A new triangle is taken every cycle while the skid entry is not full. The pipeline runs
// through the cross product, the leading-zero search and shift, the sum of squares and the
// square root (one root bit per stage over 32 bits), the three parallel dividers (one
// quotient bit per stage) and the output register. All stages move on one advance signal that
// drops only while the skid entry behind the output register is full, so one result may wait
// at the output while new triangles are still taken. A triangle whose cross product is zero
// comes out with degenerate set and all three components zero.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_isqrt, tfn_div.
module triangle_face_normal (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               triangle_valid,
	output logic               triangle_stall,
	input  tfn_pkg::triangle_t triangle,
	output logic               normal_valid,
	input  logic               normal_stall,
	output tfn_pkg::normal_t   normal
);
	import tfn_pkg::*;

	logic adv;
	logic crs_valid, nrm_valid, sqr_valid, div_valid;
	cross_t crs_data;
	scaled_t nrm_data;
	rooted_t sqr_data;
	quot_t div_data;

	normal_t res;
	normal_t main_q, skid_q;
	logic main_vld_q, skid_vld_q;
	logic push, pop;

	tfn_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.up_valid (triangle_valid),
		.up_data  (triangle),
		.dn_valid (crs_valid),
		.dn_data  (crs_data)
	);

	tfn_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.up_valid (crs_valid),
		.up_data  (crs_data),
		.dn_valid (nrm_valid),
		.dn_data  (nrm_data)
	);

	tfn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.up_valid (nrm_valid),
		.up_data  (nrm_data),
		.dn_valid (sqr_valid),
		.dn_data  (sqr_data)
	);

	tfn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.up_valid (sqr_valid),
		.up_data  (sqr_data),
		.dn_valid (div_valid),
		.dn_data  (div_data)
	);

	// sign and degenerate handling on the way into the output register
	always_comb begin
		logic [NAXES-1:0][NORMAL_W-1:0] comp;
		for (int i = 0; i < NAXES; i++) begin
			comp[i] = NORMAL_W'(div_data.quo[i]);
			if (div_data.neg[i]) comp[i] = -comp[i];
			if (div_data.degen) comp[i] = '0;
		end
		res.normal_x = comp[0];
		res.normal_y = comp[1];
		res.normal_z = comp[2];
		res.degenerate = div_data.degen;
	end

	assign adv = !skid_vld_q;
	assign push = adv && div_valid;
	assign pop = main_vld_q && !normal_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || pop) begin
			main_vld_q <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || pop) begin
			main_q <= skid_vld_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign triangle_stall = skid_vld_q;
	assign normal_valid = main_vld_q;
	assign normal = main_q;

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry full while output register empty");
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		main_vld_q && normal_stall && !skid_vld_q && div_valid |=> skid_vld_q)
		else $error("result from pipeline not caught in skid entry");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && normal.degenerate |-> (normal.normal_x == '0
			&& normal.normal_y == '0 && normal.normal_z == '0))
		else $error("degenerate result with nonzero normal");
`endif

endmodule

// ----- rtl/core/tfn_cross.sv -----
// Edge vectors and exact cross product, three pipeline stages.
// Depends on tfn_pkg.
module tfn_cross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               up_valid,
	input  tfn_pkg::triangle_t up_data,
	output logic               dn_valid,
	output tfn_pkg::cross_t    dn_data
);
	import tfn_pkg::*;

	logic vld_s1, vld_s2, vld_s3;

	logic signed [EDGE_W-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [PROD_W-1:0] yz_s2, zy_s2, zx_s2, xz_s2, xy_s2, yx_s2;
	cross_t n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= up_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// U = p2 - p1, V = p3 - p1, one extra bit so nothing wraps
			ux_s1 <= {up_data.second_x[COORD_W-1], up_data.second_x}
				- {up_data.first_x[COORD_W-1], up_data.first_x};
			uy_s1 <= {up_data.second_y[COORD_W-1], up_data.second_y}
				- {up_data.first_y[COORD_W-1], up_data.first_y};
			uz_s1 <= {up_data.second_z[COORD_W-1], up_data.second_z}
				- {up_data.first_z[COORD_W-1], up_data.first_z};
			vx_s1 <= {up_data.third_x[COORD_W-1], up_data.third_x}
				- {up_data.first_x[COORD_W-1], up_data.first_x};
			vy_s1 <= {up_data.third_y[COORD_W-1], up_data.third_y}
				- {up_data.first_y[COORD_W-1], up_data.first_y};
			vz_s1 <= {up_data.third_z[COORD_W-1], up_data.third_z}
				- {up_data.first_z[COORD_W-1], up_data.first_z};

			yz_s2 <= uy_s1 * vz_s1;
			zy_s2 <= uz_s1 * vy_s1;
			zx_s2 <= uz_s1 * vx_s1;
			xz_s2 <= ux_s1 * vz_s1;
			xy_s2 <= ux_s1 * vy_s1;
			yx_s2 <= uy_s1 * vx_s1;

			n_s3.x <= CROSS_W'(yz_s2) - CROSS_W'(zy_s2);
			n_s3.y <= CROSS_W'(zx_s2) - CROSS_W'(xz_s2);
			n_s3.z <= CROSS_W'(xy_s2) - CROSS_W'(yx_s2);
		end
	end

	assign dn_valid = vld_s3;
	assign dn_data = n_s3;

endmodule

// ----- rtl/core/tfn_norm.sv -----
// Magnitude, leading-zero count and common normalizing shift, four pipeline stages.
// Depends on tfn_pkg.
module tfn_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             up_valid,
	input  tfn_pkg::cross_t  up_data,
	output logic             dn_valid,
	output tfn_pkg::scaled_t dn_data
);
	import tfn_pkg::*;

	function automatic logic [GRP_LZ_W-1:0] grp_lz(input logic [LZ_GRP-1:0] b);
		logic [GRP_LZ_W-1:0] lz;
		lz = '0;
		for (int i = 0; i < LZ_GRP; i++) begin
			if (b[i]) lz = GRP_LZ_W'(LZ_GRP - 1 - i);
		end
		return lz;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic [NAXES-1:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [NAXES-1:0] neg_s1, neg_s2, neg_s3;
	logic [LZ_NGRP-1:0] gnz_s2;
	logic [LZ_NGRP-1:0][GRP_LZ_W-1:0] glz_s2;
	logic degen_s2, degen_s3;
	logic [LZ_W-1:0] lz_s3;
	scaled_t out_s4;

	logic signed [CROSS_W-1:0] n_in [NAXES];
	logic [NAXES-1:0][MAG_W-1:0] mag_d;
	logic [NAXES-1:0] neg_d;
	logic [MAG_W-1:0] or_all;
	logic [LZ_PAD-1:0] or_pad;
	logic [LZ_NGRP-1:0] gnz_d;
	logic [LZ_NGRP-1:0][GRP_LZ_W-1:0] glz_d;
	logic [LZ_W-1:0] lz_d;
	scaled_t out_d;

	assign n_in[0] = up_data.x;
	assign n_in[1] = up_data.y;
	assign n_in[2] = up_data.z;

	always_comb begin
		logic [MAG_W-1:0] shifted;
		logic [LZ_GRP-1:0] grp;

		for (int i = 0; i < NAXES; i++) begin
			neg_d[i] = n_in[i][CROSS_W-1];
			mag_d[i] = neg_d[i] ? MAG_W'(-n_in[i]) : MAG_W'(n_in[i]);
		end

		// leading one of the OR is the leading one of the largest magnitude
		or_all = mag_s1[0] | mag_s1[1] | mag_s1[2];
		or_pad = {or_all, {LZ_FILL{1'b0}}};
		for (int g = 0; g < LZ_NGRP; g++) begin
			grp = or_pad[LZ_PAD - 1 - g * LZ_GRP -: LZ_GRP];
			gnz_d[g] = |grp;
			glz_d[g] = grp_lz(grp);
		end

		// first nonzero group from the top
		lz_d = '0;
		for (int g = LZ_NGRP - 1; g >= 0; g--) begin
			if (gnz_s2[g]) lz_d = LZ_W'(g * LZ_GRP) + LZ_W'(glz_s2[g]);
		end

		// leading one lands on bit NORM_W-1; bits shifted out below are dropped
		for (int i = 0; i < NAXES; i++) begin
			shifted = mag_s3[i] << lz_s3;
			out_d.mag[i] = shifted[MAG_W-1 -: NORM_W];
		end
		out_d.neg = neg_s3;
		out_d.degen = degen_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= up_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag_d;
			neg_s1 <= neg_d;

			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			gnz_s2 <= gnz_d;
			glz_s2 <= glz_d;
			degen_s2 <= ~|or_all;

			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			degen_s3 <= degen_s2;
			lz_s3 <= lz_d;

			out_s4 <= out_d;
		end
	end

	assign dn_valid = vld_s4;
	assign dn_data = out_s4;

`ifndef SYNTHESIS
	a_norm_lead_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !out_s4.degen |-> (out_s4.mag[0][NORM_W-1] || out_s4.mag[1][NORM_W-1]
			|| out_s4.mag[2][NORM_W-1]))
		else $error("normalized magnitudes miss the leading one");
	a_norm_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && out_s4.degen |-> out_s4.mag == '0)
		else $error("degenerate triangle with nonzero magnitude");
`endif

endmodule

// ----- rtl/core/tfn_isqrt.sv -----
// Sum of squares and a bit-per-stage integer square root.
// Depends on tfn_pkg.
module tfn_isqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             up_valid,
	input  tfn_pkg::scaled_t up_data,
	output logic             dn_valid,
	output tfn_pkg::rooted_t dn_data
);
	import tfn_pkg::*;

	localparam int NST = ROOT_W;

	logic vld_s1;
	logic [SQ_W-1:0] sq_s1 [NAXES];
	scaled_t pay_s1;

	// index 0 holds the sum, index k the state after root bit k
	logic [NST:0] vld_s;
	logic [SQ_REM_W-1:0] rem_s [NST+1];
	logic [ROOT_W-1:0] root_s [NST+1];
	logic [SUM_W-1:0] rad_s [NST+1];
	scaled_t pay_s [NST+1];

	logic [SQ_REM_W-1:0] rem_d [NST+1];
	logic [ROOT_W-1:0] root_d [NST+1];
	logic [SUM_W-1:0] rad_d [NST+1];

	always_comb begin
		logic [SQ_REM_W-1:0] cur;
		logic [SQ_REM_W-1:0] trial;
		logic ge;

		rem_d[0] = '0;
		root_d[0] = '0;
		rad_d[0] = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);

		for (int k = 1; k <= NST; k++) begin
			cur = {rem_s[k-1][SQ_REM_W-3:0], rad_s[k-1][SUM_W-1 -: 2]};
			trial = {root_s[k-1], 2'b01};
			ge = cur >= trial;
			rem_d[k] = ge ? cur - trial : cur;
			root_d[k] = {root_s[k-1][ROOT_W-2:0], ge};
			rad_d[k] = rad_s[k-1] << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s <= '0;
		end else if (adv) begin
			vld_s1 <= up_valid;
			vld_s <= {vld_s[NST-1:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NAXES; i++) begin
				sq_s1[i] <= up_data.mag[i] * up_data.mag[i];
			end
			pay_s1 <= up_data;
			for (int k = 0; k <= NST; k++) begin
				rem_s[k] <= rem_d[k];
				root_s[k] <= root_d[k];
				rad_s[k] <= rad_d[k];
			end
			pay_s[0] <= pay_s1;
			for (int k = 1; k <= NST; k++) begin
				pay_s[k] <= pay_s[k-1];
			end
		end
	end

	always_comb begin
		dn_data.mag = pay_s[NST].mag;
		dn_data.neg = pay_s[NST].neg;
		dn_data.degen = pay_s[NST].degen;
		dn_data.root = root_s[NST];
	end
	assign dn_valid = vld_s[NST];

`ifndef SYNTHESIS
	a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST] |-> rem_s[NST] <= {root_s[NST], 1'b0})
		else $error("square root remainder out of range");
	a_sqrt_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST] && !pay_s[NST].degen |-> root_s[NST][ROOT_W-1 -: 2] != 2'b00)
		else $error("square root below the normalized floor");
`endif

endmodule

// ----- rtl/core/tfn_div.sv -----
// Rounded quotient m * 2^14 / root for three axes, one restoring step per stage.
// Depends on tfn_pkg.
module tfn_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             up_valid,
	input  tfn_pkg::rooted_t up_data,
	output logic             dn_valid,
	output tfn_pkg::quot_t   dn_data
);
	import tfn_pkg::*;

	localparam int NST = QUOT_W;
	localparam logic [QUOT_W-1:0] QUOT_MAX = QUOT_W'(1) << NORMAL_FRAC_BITS;

	// index 0 holds the prepared dividend, index k the state after quotient bit k
	logic [NST:0] vld_s;
	logic [NAXES-1:0][DIV_REM_W-1:0] rem_s [NST+1];
	logic [NAXES-1:0][QUOT_W-1:0] low_s [NST+1];
	logic [NAXES-1:0][QUOT_W-1:0] quo_s [NST+1];
	logic [ROOT_W-1:0] root_s [NST+1];
	logic [NAXES-1:0] neg_s [NST+1];
	logic [NST:0] degen_s;

	logic [NAXES-1:0][DIV_REM_W-1:0] rem_d [NST+1];
	logic [NAXES-1:0][QUOT_W-1:0] low_d [NST+1];
	logic [NAXES-1:0][QUOT_W-1:0] quo_d [NST+1];

	always_comb begin
		logic [DIVD_W-1:0] dvd;
		logic [DIV_REM_W-1:0] cur;
		logic [DIV_REM_W-1:0] dsr;
		logic ge;

		// dividend carries half the divisor so the quotient rounds to nearest
		for (int i = 0; i < NAXES; i++) begin
			dvd = DIVD_W'({up_data.mag[i], {NORMAL_FRAC_BITS{1'b0}}})
				+ DIVD_W'(up_data.root >> 1);
			rem_d[0][i] = DIV_REM_W'(dvd >> QUOT_W);
			low_d[0][i] = dvd[QUOT_W-1:0];
			quo_d[0][i] = '0;
		end

		for (int k = 1; k <= NST; k++) begin
			dsr = DIV_REM_W'(root_s[k-1]);
			for (int i = 0; i < NAXES; i++) begin
				cur = {rem_s[k-1][i][DIV_REM_W-2:0], low_s[k-1][i][QUOT_W-1]};
				ge = cur >= dsr;
				rem_d[k][i] = ge ? cur - dsr : cur;
				quo_d[k][i] = {quo_s[k-1][i][QUOT_W-2:0], ge};
				low_d[k][i] = low_s[k-1][i] << 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:0], up_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= NST; k++) begin
				rem_s[k] <= rem_d[k];
				low_s[k] <= low_d[k];
				quo_s[k] <= quo_d[k];
			end
			root_s[0] <= up_data.root;
			neg_s[0] <= up_data.neg;
			for (int k = 1; k <= NST; k++) begin
				root_s[k] <= root_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
			degen_s <= {degen_s[NST-1:0], up_data.degen};
		end
	end

	always_comb begin
		dn_data.quo = quo_s[NST];
		dn_data.neg = neg_s[NST];
		dn_data.degen = degen_s[NST];
	end
	assign dn_valid = vld_s[NST];

`ifndef SYNTHESIS
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST] && !degen_s[NST] |-> (rem_s[NST][0] < DIV_REM_W'(root_s[NST])
			&& rem_s[NST][1] < DIV_REM_W'(root_s[NST])
			&& rem_s[NST][2] < DIV_REM_W'(root_s[NST])))
		else $error("division remainder not below divisor");
	a_div_unit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST] && !degen_s[NST] |-> (quo_s[NST][0] <= QUOT_MAX
			&& quo_s[NST][1] <= QUOT_MAX && quo_s[NST][2] <= QUOT_MAX))
		else $error("normal component above one");
`endif

endmodule

// ----- tb/triangle_face_normal_tb.sv -----
// Self-checking testbench for triangle_face_normal: unit face normals in Q1.14 from triangles.
// Runs directed rows, then random triangles, with random idles and stalls on both sides.
// Depends on tfn_pkg and triangle_face_normal.
module triangle_face_normal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tfn_pkg::*;

	localparam int RANDOM_ITEMS = 1600;
	localparam int MAX_IDLE = 13;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AT = 500;
	localparam int REPORT_LIMIT = 10;
	localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN = -(1 << (COORD_W - 1));
	localparam logic signed [NORMAL_W-1:0] UNIT_LEN = NORMAL_W'(1 << NORMAL_FRAC_BITS);
	localparam logic [63:0] SCALE_HI = 64'd1 << NORM_W;
	localparam logic [63:0] SCALE_LO = 64'd1 << (NORM_W - 1);

	typedef struct {
		triangle_t tri_in;
		bit        known;
		normal_t   want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      triangle_valid;
	logic      triangle_stall;
	triangle_t triangle;
	logic      normal_valid;
	logic      normal_stall;
	normal_t   normal;

	// expectation that travels with the offered triangle
	bit        offer_known;
	normal_t   offer_normal;

	normal_t   pending_normals[$];
	stim_row_t directed_rows[$];
	int        fail_count = 0;

	triangle_face_normal uut (
		.clk(clk),
		.arst_n(arst_n),
		.triangle_valid(triangle_valid),
		.triangle_stall(triangle_stall),
		.triangle(triangle),
		.normal_valid(normal_valid),
		.normal_stall(normal_stall),
		.normal(normal)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz);
		triangle_t t;
		t.first_x = ax[COORD_W-1:0];
		t.first_y = ay[COORD_W-1:0];
		t.first_z = az[COORD_W-1:0];
		t.second_x = bx[COORD_W-1:0];
		t.second_y = by[COORD_W-1:0];
		t.second_z = bz[COORD_W-1:0];
		t.third_x = cx[COORD_W-1:0];
		t.third_y = cy[COORD_W-1:0];
		t.third_z = cz[COORD_W-1:0];
		return t;
	endfunction

	function automatic void add_row(triangle_t t, bit known, normal_t want);
		directed_rows.insert(directed_rows.size(), '{t, known, want});
	endfunction

	// exact cross product, common scaling into [2^30, 2^31), isqrt, rounded divide
	function automatic normal_t face_normal(triangle_t t);
		longint ux, uy, uz, vx, vy, vz;
		longint n[3];
		logic [63:0] m[3];
		bit neg[3];
		logic [63:0] big, rem, root, bitpos, q;
		logic [NORMAL_W-1:0] comp[3];
		normal_t res;
		ux = longint'($signed(t.second_x)) - longint'($signed(t.first_x));
		uy = longint'($signed(t.second_y)) - longint'($signed(t.first_y));
		uz = longint'($signed(t.second_z)) - longint'($signed(t.first_z));
		vx = longint'($signed(t.third_x)) - longint'($signed(t.first_x));
		vy = longint'($signed(t.third_y)) - longint'($signed(t.first_y));
		vz = longint'($signed(t.third_z)) - longint'($signed(t.first_z));
		n[0] = uy * vz - uz * vy;
		n[1] = uz * vx - ux * vz;
		n[2] = ux * vy - uy * vx;
		for (int i = 0; i < 3; i++) begin
			neg[i] = n[i] < 0;
			m[i] = neg[i] ? -n[i] : n[i];
		end
		if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
			res.normal_x = '0;
			res.normal_y = '0;
			res.normal_z = '0;
			res.degenerate = 1'b1;
			return res;
		end
		big = m[0];
		if (m[1] > big) big = m[1];
		if (m[2] > big) big = m[2];
		while (big >= SCALE_HI) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			big = big >> 1;
		end
		while (big < SCALE_LO) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			big = big << 1;
		end
		rem = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		root = 64'd0;
		bitpos = 64'd1 << 62;
		while (bitpos > rem) bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (rem >= root + bitpos) begin
				rem = rem - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << NORMAL_FRAC_BITS) + (root >> 1)) / root;
			if (neg[i]) q = -q;
			comp[i] = q[NORMAL_W-1:0];
		end
		res.normal_x = comp[0];
		res.normal_y = comp[1];
		res.normal_z = comp[2];
		res.degenerate = 1'b0;
		return res;
	endfunction

	// both channels observed at the rising edge
	always @(posedge clk) begin
		normal_t want;
		if (arst_n) begin
			if (normal_valid && !normal_stall) begin
				if (pending_normals.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display(
							"unexpected normal transaction: x=%0d y=%0d z=%0d degenerate=%0b",
							normal.normal_x, normal.normal_y, normal.normal_z,
							normal.degenerate);
				end else begin
					want = pending_normals.pop_front();
					if (normal.normal_x !== want.normal_x || normal.normal_y !== want.normal_y ||
						normal.normal_z !== want.normal_z ||
						normal.degenerate !== want.degenerate) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("normal mismatch: expected x=%0d y=%0d z=%0d degenerate=%0b",
								want.normal_x, want.normal_y, want.normal_z, want.degenerate);
							$display("                 got      x=%0d y=%0d z=%0d degenerate=%0b",
								normal.normal_x, normal.normal_y, normal.normal_z,
								normal.degenerate);
						end
					end
				end
			end
			if (triangle_valid && !triangle_stall)
				pending_normals.insert(pending_normals.size(),
					offer_known ? offer_normal : face_normal(triangle));
		end
	end

	task automatic send_triangle(triangle_t t, bit known, normal_t want, bit no_idle);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		repeat (gap) begin
			@(negedge clk);
			triangle_valid <= 1'b0;
		end
		@(negedge clk);
		triangle_valid <= 1'b1;
		triangle <= t;
		offer_known <= known;
		offer_normal <= want;
		do @(posedge clk); while (triangle_stall !== 1'b0);
	endtask

	// receiver: random stalls, idle-free stretches and one long hold-off
	initial begin
		int wait_cycles;
		int taken;
		taken = 0;
		normal_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_OFF_AT)
				wait_cycles = HOLD_OFF_CYCLES;
			else if (taken % 350 < 80)
				wait_cycles = 0;
			else
				wait_cycles = $urandom_range(0, MAX_IDLE);
			repeat (wait_cycles) begin
				@(negedge clk);
				normal_stall <= 1'b1;
			end
			@(negedge clk);
			normal_stall <= 1'b0;
			do @(posedge clk); while (normal_valid !== 1'b1);
			taken++;
		end
	end

	initial begin
		normal_t none;
		normal_t degen;
		int c[9];
		int sel, k, d[3], s, h[3], gx, gz;
		triangle_t t;

		triangle_valid = 1'b0;
		triangle = '0;
		offer_known = 1'b0;
		offer_normal = '0;
		arst_n = 1'b0;
		none = '0;
		degen = '0;
		degen.degenerate = 1'b1;

		// coincident and collinear vertices
		add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, degen);
		add_row(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 1'b1, degen);
		add_row(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), 1'b1, degen);
		add_row(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, degen);
		add_row(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0,
			COORD_MAX, COORD_MAX, COORD_MAX), 1'b1, degen);
		// axis normals, smallest and largest edges
		add_row(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1,
			'{16'sd0, 16'sd0, UNIT_LEN, 1'b0});
		add_row(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b1,
			'{16'sd0, 16'sd0, -UNIT_LEN, 1'b0});
		add_row(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
			'{UNIT_LEN, 16'sd0, 16'sd0, 1'b0});
		add_row(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0), 1'b1,
			'{16'sd0, UNIT_LEN, 16'sd0, 1'b0});
		add_row(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0), 1'b1,
			'{-UNIT_LEN, 16'sd0, 16'sd0, 1'b0});
		add_row(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN), 1'b1,
			'{16'sd0, 16'sd0, UNIT_LEN, 1'b0});
		add_row(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX), 1'b1,
			'{16'sd0, UNIT_LEN, 16'sd0, 1'b0});
		// general directions, checked against the predictor
		add_row(make_tri(0, 0, 0, 1, -1, 0, 0, 1, -1), 1'b0, none);
		add_row(make_tri(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN), 1'b0, none);
		add_row(make_tri(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX), 1'b0, none);
		add_row(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 256), 1'b0, none);
		add_row(make_tri(3, 5, 7, -2, 9, 1, 4, -6, 8), 1'b0, none);
		add_row(make_tri(-1, -1, -1, 'h555555, 'haaaaaa, 'h555555,
			'haaaaaa, 'h555555, 'haaaaaa), 1'b0, none);
		add_row(make_tri(0, 0, 0, 1, 0, 0, 0, COORD_MAX, 1), 1'b0, none);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_triangle(directed_rows[i].tri_in, directed_rows[i].known,
				directed_rows[i].want, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				// full 24-bit patterns
				foreach (c[i]) c[i] = $urandom;
			end else if (sel < 60) begin
				// terrain cell: grid in x/z, random heights
				s = 256 * $urandom_range(1, 16);
				gx = $urandom_range(0, 1 << 21) - (1 << 20);
				gz = $urandom_range(0, 1 << 21) - (1 << 20);
				foreach (h[i]) h[i] = $urandom_range(0, 1 << 17) - (1 << 16);
				case ($urandom_range(0, 1))
					0: c = '{gx, h[0], gz, gx + s, h[1], gz, gx, h[2], gz + s};
					default: c = '{gx + s, h[0], gz + s, gx, h[1], gz + s, gx + s, h[2], gz};
				endcase
			end else if (sel < 75) begin
				// tiny triangles, left-shift scaling
				foreach (c[i]) c[i] = $urandom_range(0, 200) - 100;
			end else if (sel < 87) begin
				// degenerate: coincident or collinear
				for (int i = 0; i < 3; i++) begin
					c[i] = $urandom_range(0, 2000) - 1000;
					d[i] = $urandom_range(0, 2000) - 1000;
				end
				k = $urandom_range(0, 10) - 5;
				case ($urandom_range(0, 3))
					0: c = '{c[0], c[1], c[2], c[0], c[1], c[2], c[0] + d[0], c[1] + d[1],
						c[2] + d[2]};
					1: c = '{c[0], c[1], c[2], c[0] + d[0], c[1] + d[1], c[2] + d[2],
						c[0], c[1], c[2]};
					2: c = '{c[0], c[1], c[2], c[0], c[1], c[2], c[0], c[1], c[2]};
					default: c = '{c[0], c[1], c[2], c[0] + d[0], c[1] + d[1], c[2] + d[2],
						c[0] + k * d[0], c[1] + k * d[1], c[2] + k * d[2]};
				endcase
			end else begin
				// corner values mixed with noise
				foreach (c[i]) begin
					case ($urandom_range(0, 5))
						0: c[i] = COORD_MIN;
						1: c[i] = COORD_MAX;
						2: c[i] = 0;
						3: c[i] = -1;
						4: c[i] = 1;
						default: c[i] = $urandom;
					endcase
				end
			end
			t = make_tri(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
			send_triangle(t, 1'b0, none, (n % 400) < 100);
		end

		@(negedge clk);
		triangle_valid <= 1'b0;

		while (pending_normals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_normals.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
